// ===== design/ilid_pkg.sv =====
`timescale 1ns / 1ps
// Package for the indexed list block: capacity, widths, command and status
// codes, request and result structs, and the controller-to-datapath link.
// Depends on nothing.
package ilid_pkg;

  localparam int Capacity = 16;
  localparam int IdxW     = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int CmpW     = (CntW > 5) ? CntW : 5;

  localparam logic [2:0] CmdAppend  = 3'd0;
  localparam logic [2:0] CmdInsert  = 3'd1;
  localparam logic [2:0] CmdDelete  = 3'd2;
  localparam logic [2:0] CmdReplace = 3'd3;
  localparam logic [2:0] CmdRead    = 3'd4;

  localparam logic [1:0] StatDone  = 2'd0;
  localparam logic [1:0] StatFull  = 2'd1;
  localparam logic [1:0] StatRange = 2'd2;

  typedef struct packed {
    logic [2:0]          command;
    logic [4:0]          index;
    logic signed [31:0]  value;
  } req_t;

  typedef struct packed {
    logic signed [31:0]  read_value;
    logic [4:0]          count;
    logic [1:0]          status;
  } rsp_t;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_APPEND  = 3'd1,
    OP_INSERT  = 3'd2,
    OP_DELETE  = 3'd3,
    OP_REPLACE = 3'd4,
    OP_READ    = 3'd5
  } dp_op_e;

  typedef struct packed {
    logic        load;
    dp_op_e      op;
    logic [1:0]  status;
  } dp_cmd_t;

  typedef struct packed {
    logic [CntW-1:0] count;
  } dp_stat_t;

endpackage

// ===== design/ilid_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the indexed list: a row of shift-register cells, the entry
// count and the result register. Depends on ilid_pkg.
module ilid_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ilid_pkg::dp_cmd_t      cmd_i,
  input  logic [4:0]             index_i,
  input  logic signed [31:0]     value_i,
  output ilid_pkg::dp_stat_t     stat_o,
  output ilid_pkg::rsp_t         rsp_o
);

  logic [31:0]                     entries_q [ilid_pkg::Capacity];
  logic [31:0]                     entries_d [ilid_pkg::Capacity];
  logic [ilid_pkg::CntW-1:0]       count_q, count_d;
  ilid_pkg::rsp_t                  rsp_q, rsp_d;
  logic [ilid_pkg::CmpW-1:0]       idx_ext, cnt_ext, cnt_next_ext;
  logic [ilid_pkg::IdxW-1:0]       rd_addr;

  assign idx_ext = ilid_pkg::CmpW'(index_i);
  assign cnt_ext = ilid_pkg::CmpW'(count_q);
  assign rd_addr = idx_ext[ilid_pkg::IdxW-1:0];

  for (genvar i = 0; i < ilid_pkg::Capacity; i++) begin : g_cell
    localparam logic [ilid_pkg::CmpW-1:0] Pos = ilid_pkg::CmpW'(i);
    logic [31:0] prev_w, next_w;

    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_prev
      assign prev_w = entries_q[i-1];
    end

    if (i == ilid_pkg::Capacity - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_next
      assign next_w = entries_q[i+1];
    end

    always_comb begin
      entries_d[i] = entries_q[i];
      unique case (cmd_i.op)
        ilid_pkg::OP_APPEND: begin
          if (Pos == cnt_ext) entries_d[i] = value_i;
        end
        ilid_pkg::OP_INSERT: begin
          if (Pos == idx_ext) begin
            entries_d[i] = value_i;
          end else if (Pos > idx_ext && Pos <= cnt_ext) begin
            entries_d[i] = prev_w;
          end
        end
        ilid_pkg::OP_DELETE: begin
          if (Pos >= idx_ext && Pos < cnt_ext) entries_d[i] = next_w;
        end
        ilid_pkg::OP_REPLACE: begin
          if (Pos == idx_ext) entries_d[i] = value_i;
        end
        default: begin
          entries_d[i] = entries_q[i];
        end
      endcase
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        entries_q[i] <= '0;
      end else begin
        entries_q[i] <= entries_d[i];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    unique case (cmd_i.op)
      ilid_pkg::OP_APPEND, ilid_pkg::OP_INSERT: count_d = count_q + 1'b1;
      ilid_pkg::OP_DELETE:                      count_d = count_q - 1'b1;
      default:                                  count_d = count_q;
    endcase
  end

  assign cnt_next_ext = ilid_pkg::CmpW'(count_d);

  always_comb begin
    rsp_d            = rsp_q;
    if (cmd_i.load) begin
      rsp_d.read_value = (cmd_i.op == ilid_pkg::OP_READ) ? entries_q[rd_addr] : '0;
      rsp_d.count      = cnt_next_ext[4:0];
      rsp_d.status     = cmd_i.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign stat_o.count = count_q;
  assign rsp_o        = rsp_q;

  // The count never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ilid_pkg::CntW'(ilid_pkg::Capacity))
    else $error("entry count above capacity");

  // A rejected request leaves the count as it was.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load && cmd_i.status != ilid_pkg::StatDone |=> $stable(count_q))
    else $error("rejected request changed the count");

  // The slot just past the last entry always holds zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < ilid_pkg::CntW'(ilid_pkg::Capacity) |->
      entries_q[count_q[ilid_pkg::IdxW-1:0]] == '0)
    else $error("unused slot is not zero");

endmodule

// ===== design/ilid_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the indexed list: handshake state machine and the request
// decode with range and room checks. Depends on ilid_pkg.
module ilid_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            command_i,
  input  logic [4:0]            index_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  ilid_pkg::dp_stat_t    stat_i,
  output ilid_pkg::dp_cmd_t     cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_HOLD = 2'b10
  } ctl_state_e;

  ctl_state_e                  state_q, state_d;
  logic                        accept;
  logic                        full;
  logic [ilid_pkg::CmpW-1:0]   idx_ext, cnt_ext;
  ilid_pkg::dp_op_e            op;
  logic [1:0]                  status;

  assign in_ready_o  = (state_q == S_IDLE) || out_ready_i;
  assign out_valid_o = (state_q == S_HOLD);
  assign accept      = in_valid_i && in_ready_o;

  assign idx_ext = ilid_pkg::CmpW'(index_i);
  assign cnt_ext = ilid_pkg::CmpW'(stat_i.count);
  assign full    = (stat_i.count == ilid_pkg::CntW'(ilid_pkg::Capacity));

  always_comb begin
    op     = ilid_pkg::OP_NONE;
    status = ilid_pkg::StatDone;
    unique case (command_i)
      ilid_pkg::CmdAppend: begin
        if (full) status = ilid_pkg::StatFull;
        else      op     = ilid_pkg::OP_APPEND;
      end
      ilid_pkg::CmdInsert: begin
        priority if (idx_ext > cnt_ext) status = ilid_pkg::StatRange;
        else if (full)                  status = ilid_pkg::StatFull;
        else                            op     = ilid_pkg::OP_INSERT;
      end
      ilid_pkg::CmdDelete: begin
        if (idx_ext >= cnt_ext) status = ilid_pkg::StatRange;
        else                    op     = ilid_pkg::OP_DELETE;
      end
      ilid_pkg::CmdReplace: begin
        if (idx_ext >= cnt_ext) status = ilid_pkg::StatRange;
        else                    op     = ilid_pkg::OP_REPLACE;
      end
      ilid_pkg::CmdRead: begin
        if (idx_ext >= cnt_ext) status = ilid_pkg::StatRange;
        else                    op     = ilid_pkg::OP_READ;
      end
      default: begin
        op     = ilid_pkg::OP_NONE;
        status = ilid_pkg::StatDone;
      end
    endcase
  end

  assign cmd_o.load   = accept;
  assign cmd_o.op     = accept ? op : ilid_pkg::OP_NONE;
  assign cmd_o.status = status;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_HOLD;
      end
      S_HOLD: begin
        if (out_ready_i && !accept) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A new request never overwrites a result that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && out_valid_o |-> out_ready_i)
    else $error("result overwritten before it was taken");

  // Only a request that passes its checks reaches the cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op != ilid_pkg::OP_NONE |-> cmd_o.load && cmd_o.status == ilid_pkg::StatDone)
    else $error("rejected request issued to the datapath");

  // Every accepted request leaves a result pending on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted request gave no result");

endmodule

// ===== design/indexed_list_insert_delete.sv =====
`timescale 1ns / 1ps
// Top level of the indexed list with insert and delete: joins the controller
// and the datapath. Depends on ilid_pkg, ilid_ctrl and ilid_datapath.
//
//   Channel   Handshake                   Payload
//   request   in_valid_i / in_ready_o     in_req_i  (command, index, value)
//   result    out_valid_o / out_ready_i   out_rsp_o (read_value, count, status)
//
// Each request completes at its accepting edge: all cells shift in parallel and
// the result register loads at that same edge.
// A new request is taken while the previous result is being taken, so one
// request per cycle is sustained when the result side does not stall.
// Reset clears all entries and the count at once; no sweep follows reset.
// While a result waits and out_ready_i is low, in_ready_o is low.
module indexed_list_insert_delete (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ilid_pkg::req_t   in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ilid_pkg::rsp_t   out_rsp_o
);

  ilid_pkg::dp_cmd_t  dp_cmd;
  ilid_pkg::dp_stat_t dp_stat;

  ilid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (in_req_i.command),
    .index_i     (in_req_i.index),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  ilid_datapath u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (dp_cmd),
    .index_i (in_req_i.index),
    .value_i (in_req_i.value),
    .stat_o  (dp_stat),
    .rsp_o   (out_rsp_o)
  );

endmodule

// ===== tb/indexed_list_insert_delete_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for indexed_list_insert_delete: drives list requests under
// random idling and stalls, predicts each result with a local list model and
// compares field by field. Depends on ilid_pkg and the indexed_list_insert_delete RTL.
module indexed_list_insert_delete_test;

  localparam logic [2:0] CmdUnusedFirst = 3'd5;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  ilid_pkg::req_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  ilid_pkg::rsp_t out_rsp_o;

  logic signed [31:0] list_words [ilid_pkg::Capacity];
  int list_len = 0;
  ilid_pkg::rsp_t expected_rsps [$];
  int error_count = 0;
  int sender_idle_pct = 0;
  int recv_idle_pct = 0;
  int ready_hold_left = 0;

  indexed_list_insert_delete dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("[indexed_list_insert_delete] ERROR");
    $finish;
  end

  function automatic ilid_pkg::rsp_t apply_list_command(ilid_pkg::req_t r);
    ilid_pkg::rsp_t rsp;
    int n;
    int i;
    rsp = '0;
    rsp.status = ilid_pkg::StatDone;
    n = list_len;
    case (r.command)
      ilid_pkg::CmdAppend: begin
        if (n >= ilid_pkg::Capacity) begin
          rsp.status = ilid_pkg::StatFull;
        end else begin
          list_words[n] = r.value;
          n++;
        end
      end
      ilid_pkg::CmdInsert: begin
        if (int'(r.index) > n) begin
          rsp.status = ilid_pkg::StatRange;
        end else if (n >= ilid_pkg::Capacity) begin
          rsp.status = ilid_pkg::StatFull;
        end else begin
          for (i = n; i > int'(r.index); i--) list_words[i] = list_words[i - 1];
          list_words[r.index] = r.value;
          n++;
        end
      end
      ilid_pkg::CmdDelete: begin
        if (int'(r.index) >= n) begin
          rsp.status = ilid_pkg::StatRange;
        end else begin
          for (i = r.index; i + 1 < n; i++) list_words[i] = list_words[i + 1];
          list_words[n - 1] = '0;
          n--;
        end
      end
      ilid_pkg::CmdReplace: begin
        if (int'(r.index) >= n) rsp.status = ilid_pkg::StatRange;
        else list_words[r.index] = r.value;
      end
      ilid_pkg::CmdRead: begin
        if (int'(r.index) >= n) rsp.status = ilid_pkg::StatRange;
        else rsp.read_value = list_words[r.index];
      end
      default: begin
      end
    endcase
    list_len = n;
    rsp.count = n[4:0];
    return rsp;
  endfunction

  task automatic send_request(input ilid_pkg::req_t r);
    int gap;
    ilid_pkg::rsp_t want_rsp;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    want_rsp = apply_list_command(r);
    expected_rsps = {expected_rsps, want_rsp};
  endtask

  task automatic send_fields(input logic [2:0] cmd, input logic [4:0] idx,
                             input logic signed [31:0] val);
    ilid_pkg::req_t r;
    r.command = cmd;
    r.index = idx;
    r.value = val;
    send_request(r);
  endtask

  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_rsps.size() != 0);
  endtask

  always @(posedge clk_i) begin
    if (ready_hold_left > 0) begin
      out_ready_i <= 1'b0;
      ready_hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    ilid_pkg::rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rsps.size() == 0) begin
        $error("Result arrived with no request outstanding.");
        error_count++;
      end else begin
        want = expected_rsps.pop_front();
        if (out_rsp_o.read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, out_rsp_o.read_value);
          error_count++;
        end
        if (out_rsp_o.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_rsp_o.count);
          error_count++;
        end
        if (out_rsp_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_rsp_o.status);
          error_count++;
        end
      end
    end
  end

  task automatic test_directed();
    send_fields(ilid_pkg::CmdRead, 5'd0, 32'sd0);
    send_fields(ilid_pkg::CmdDelete, 5'd0, 32'sd0);
    send_fields(ilid_pkg::CmdReplace, 5'd0, 32'sd7);
    send_fields(ilid_pkg::CmdInsert, 5'd1, 32'sd9);
    send_fields(ilid_pkg::CmdInsert, 5'd0, 32'sh8000_0000);
    send_fields(ilid_pkg::CmdAppend, 5'd0, 32'sh7FFF_FFFF);
    send_fields(ilid_pkg::CmdAppend, 5'd17, -32'sd1);
    send_fields(ilid_pkg::CmdInsert, 5'd1, 32'sd0);
    send_fields(ilid_pkg::CmdInsert, 5'd4, 32'sh5A5A_5A5A);
    send_fields(ilid_pkg::CmdRead, 5'd4, 32'sd0);
    send_fields(ilid_pkg::CmdRead, 5'd0, 32'sd0);
    send_fields(ilid_pkg::CmdReplace, 5'd2, 32'sh1234_5678);
    send_fields(ilid_pkg::CmdRead, 5'd2, 32'sd0);
    send_fields(ilid_pkg::CmdDelete, 5'd1, 32'sd0);
    send_fields(ilid_pkg::CmdDelete, 5'd3, 32'sd0);
    send_fields(ilid_pkg::CmdRead, 5'd3, 32'sd0);
    for (int k = 0; k < 3; k++) send_fields(CmdUnusedFirst + 3'(k), 5'd31, -32'sd1);
    send_fields(ilid_pkg::CmdRead, 5'd31, 32'sd0);
    send_fields(ilid_pkg::CmdAppend, 5'd31, 32'sh0F0F_F0F0);
    send_fields(ilid_pkg::CmdDelete, 5'd0, 32'sd0);
    wait_results_done();
  endtask

  // The receiver stalls long enough for the block to back up; the appends
  // also drive the list to full, where inserts must be rejected.
  task automatic test_backpressure();
    sender_idle_pct = 0;
    recv_idle_pct = 0;
    ready_hold_left = 60;
    for (int k = 0; k < 22; k++) send_fields(ilid_pkg::CmdAppend, 5'($urandom), $urandom);
    send_fields(ilid_pkg::CmdInsert, 5'(list_len), 32'sd1);
    send_fields(ilid_pkg::CmdInsert, 5'(list_len + 1), 32'sd2);
    send_fields(ilid_pkg::CmdInsert, 5'd0, 32'sd3);
    send_fields(ilid_pkg::CmdReplace, 5'(ilid_pkg::Capacity - 1), 32'sh8000_0000);
    send_fields(ilid_pkg::CmdRead, 5'(ilid_pkg::Capacity - 1), 32'sd0);
    send_fields(ilid_pkg::CmdRead, 5'(ilid_pkg::Capacity), 32'sd0);
    wait_results_done();
  endtask

  task automatic test_random(input int num_requests);
    ilid_pkg::req_t r;
    int pick;
    logic growing;
    growing = 1'b1;
    for (int k = 0; k < num_requests; k++) begin
      if (k % 40 == 39) growing = ~growing;
      pick = $urandom_range(99);
      if (growing) begin
        if (pick < 35) r.command = ilid_pkg::CmdAppend;
        else if (pick < 55) r.command = ilid_pkg::CmdInsert;
        else if (pick < 65) r.command = ilid_pkg::CmdDelete;
        else if (pick < 78) r.command = ilid_pkg::CmdReplace;
        else if (pick < 96) r.command = ilid_pkg::CmdRead;
        else r.command = CmdUnusedFirst + 3'($urandom_range(2));
      end else begin
        if (pick < 5) r.command = ilid_pkg::CmdAppend;
        else if (pick < 10) r.command = ilid_pkg::CmdInsert;
        else if (pick < 60) r.command = ilid_pkg::CmdDelete;
        else if (pick < 75) r.command = ilid_pkg::CmdReplace;
        else if (pick < 96) r.command = ilid_pkg::CmdRead;
        else r.command = CmdUnusedFirst + 3'($urandom_range(2));
      end
      if ($urandom_range(9) == 0) r.index = 5'($urandom_range(31));
      else if (r.command == ilid_pkg::CmdInsert) r.index = 5'($urandom_range(list_len));
      else r.index = (list_len > 0) ? 5'($urandom_range(list_len - 1)) : 5'd0;
      case ($urandom_range(7))
        0: r.value = 32'sh8000_0000;
        1: r.value = 32'sh7FFF_FFFF;
        2: r.value = -32'sd1;
        default: r.value = $urandom;
      endcase
      send_request(r);
    end
    wait_results_done();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    sender_idle_pct = 14;
    recv_idle_pct = 65;
    test_directed();
    test_backpressure();
    sender_idle_pct = 14;
    recv_idle_pct = 65;
    test_random(160);
    sender_idle_pct = 65;
    recv_idle_pct = 14;
    test_random(160);
    sender_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(160);
    repeat (10) @(posedge clk_i);
    if (expected_rsps.size() != 0) begin
      $error("%0d expected results never arrived.", expected_rsps.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("[indexed_list_insert_delete] OK");
    end else begin
      $display("[indexed_list_insert_delete] ERROR");
    end
    $finish;
  end

endmodule
